>>> rtl/kifp_pkg.sv
// Package for the key injection frame parser.
// Protocol byte codes and the key result word type; no dependencies.
`default_nettype none

package kifp_pkg;

	localparam logic [7:0] SYNC_A     = 8'h55;
	localparam logic [7:0] SYNC_B     = 8'hAA;
	localparam logic [7:0] T_KEY      = 8'h03;
	localparam logic [7:0] T_KEY_LONG = 8'h04;
	localparam logic [7:0] T_BATCH    = 8'h05;
	localparam logic [15:0] BATCH_MAX = 16'd128;
	localparam logic [7:0] FLAG_LONG  = 8'h01;

	typedef struct packed {
		logic       key_valid;
		logic       key_long;
		logic [7:0] key_code;
		logic       link_alive;
	} key_res_t;

endpackage

`default_nettype wire

>>> rtl/kifp_if.sv
// Stream interfaces for the key injection frame parser.
// Receive byte channel and key result channel; no dependencies.
`default_nettype none

interface kifp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface kifp_key_if;
	logic       valid;
	logic       ready;
	logic       key_valid;
	logic       key_long;
	logic [7:0] key_code;
	logic       link_alive;

	modport source (output valid, output key_valid, output key_long, output key_code,
		output link_alive, input ready);
	modport sink (input valid, input key_valid, input key_long, input key_code,
		input link_alive, output ready);
endinterface

`default_nettype wire

>>> rtl/key_injection_frame_parser.sv
// Top level of the key injection frame parser.
// Depends on kifp_pkg, kifp_if, kifp_parser and kifp_out_buf.
//
//   channel  dir  modport  word
//   rx       in   sink     rx_byte
//   key      out  source   key_valid, key_long, key_code, link_alive
//
// One byte per cycle while rx.ready is high. Parser state updates at the
// accepting edge; a result word, when the byte makes one, is registered
// into the buffer that drives key. Two result words can be held, so rx
// keeps flowing while key stalls; rx.ready drops only when both entries are full.
// arst_n clears the parser to idle and empties the result buffer.
`default_nettype none

module key_injection_frame_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	kifp_rx_if.sink   rx,
	kifp_key_if.source key
);

	logic               push;
	logic               can_push;
	logic               res_valid;
	kifp_pkg::key_res_t res;
	kifp_pkg::key_res_t out_res;

	assign rx.ready = can_push;
	assign push     = rx.valid && can_push;

	kifp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx.rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	kifp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.can_push  (can_push),
		.out_valid (key.valid),
		.out_ready (key.ready),
		.out_res   (out_res)
	);

	assign key.key_valid  = out_res.key_valid;
	assign key.key_long   = out_res.key_long;
	assign key.key_code   = out_res.key_code;
	assign key.link_alive = out_res.link_alive;

endmodule

`default_nettype wire

>>> rtl/kifp_parser.sv
// Byte-level deframing state machine of the key injection frame parser.
// Depends on kifp_pkg for byte codes and the result word type.
`default_nettype none

module kifp_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [7:0]        rx_byte,
	output logic                   res_valid,
	output kifp_pkg::key_res_t     res
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_GOT55  = 4'd1,
		PH_GOTAA  = 4'd2,
		PH_TYPE   = 4'd3,
		PH_KEY    = 4'd4,
		PH_LEN_HI = 4'd5,
		PH_LEN_LO = 4'd6,
		PH_BKEY   = 4'd7,
		PH_BFLAG  = 4'd8,
		PH_SKIP   = 4'd9
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [15:0] rem_q, rem_d;
	logic [7:0]  pend_q, pend_d;

	logic [15:0] size;
	logic [15:0] rem_dec;
	logic        batch_ok;

	assign size     = {len_hi_q, rx_byte};
	assign rem_dec  = rem_q - 16'd1;
	assign batch_ok = (type_q == kifp_pkg::T_BATCH) && (size <= kifp_pkg::BATCH_MAX)
		&& !size[0];

	always_comb begin
		phase_d  = PH_IDLE;
		type_d   = type_q;
		len_hi_d = len_hi_q;
		rem_d    = rem_q;
		pend_d   = pend_q;
		res      = '0;
		unique case (phase_q)
			PH_GOT55: begin
				res.link_alive = (rx_byte == kifp_pkg::SYNC_B);
			end
			PH_GOTAA: begin
				phase_d = (rx_byte == kifp_pkg::SYNC_A) ? PH_TYPE : PH_IDLE;
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				phase_d = (rx_byte == kifp_pkg::T_KEY || rx_byte == kifp_pkg::T_KEY_LONG)
					? PH_KEY : PH_LEN_HI;
			end
			PH_KEY: begin
				res.key_valid  = 1'b1;
				res.key_long   = (type_q == kifp_pkg::T_KEY_LONG);
				res.key_code   = rx_byte;
				res.link_alive = 1'b1;
			end
			PH_LEN_HI: begin
				len_hi_d = rx_byte;
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rem_d = size;
				if (batch_ok) begin
					// empty batch completes on the length byte itself
					res.link_alive = (size == '0);
					phase_d        = (size == '0) ? PH_IDLE : PH_BKEY;
				end else begin
					phase_d = (size == '0) ? PH_IDLE : PH_SKIP;
				end
			end
			PH_BKEY: begin
				pend_d  = rx_byte;
				rem_d   = rem_dec;
				phase_d = PH_BFLAG;
			end
			PH_BFLAG: begin
				rem_d          = rem_dec;
				res.key_valid  = 1'b1;
				res.key_long   = |(rx_byte & kifp_pkg::FLAG_LONG);
				res.key_code   = pend_q;
				res.link_alive = (rem_dec == '0);
				phase_d        = (rem_dec == '0) ? PH_IDLE : PH_BKEY;
			end
			PH_SKIP: begin
				rem_d   = rem_dec;
				phase_d = (rem_dec == '0) ? PH_IDLE : PH_SKIP;
			end
			default: begin
				if (rx_byte == kifp_pkg::SYNC_A)
					phase_d = PH_GOT55;
				else if (rx_byte == kifp_pkg::SYNC_B)
					phase_d = PH_GOTAA;
			end
		endcase
	end

	assign res_valid = push && (res.key_valid || res.link_alive);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			type_q   <= '0;
			len_hi_q <= '0;
			rem_q    <= '0;
			pend_q   <= '0;
		end else if (push) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			len_hi_q <= len_hi_d;
			rem_q    <= rem_d;
			pend_q   <= pend_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/kifp_out_buf.sv
// Two-entry result buffer (output register plus skid) of the frame parser.
// Depends on kifp_pkg for the result word type.
`default_nettype none

module kifp_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire kifp_pkg::key_res_t push_res,
	output logic                    can_push,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output kifp_pkg::key_res_t      out_res
);

	kifp_pkg::key_res_t main_q, skid_q;
	logic               main_valid_q, skid_valid_q;
	logic               pop;

	assign can_push  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				if (!main_valid_q)
					main_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_res;
		end else if (push) begin
			if (!main_valid_q)
				main_q <= push_res;
			else
				skid_q <= push_res;
		end
	end

endmodule

`default_nettype wire
